// File: hw/rtl/hsr_pkg.sv
// Shared types, constants and the FNV-1a step function for the hash shard router.
// No dependencies; every other file of the block imports this package.
package hsr_pkg;

  localparam int unsigned HashBits     = 64;
  localparam int unsigned ShardBits    = 16;
  localparam int unsigned SHARD_ID_BITS = 16;
  localparam int unsigned QDepth       = 4;
  localparam int unsigned QPtrBits     = $clog2(QDepth);
  localparam int unsigned DivCntBits   = $clog2(HashBits);

  localparam logic [HashBits-1:0] FnvBasis = 64'hCBF2_9CE4_8422_2325;

  localparam logic [DivCntBits-1:0] DivLast = DivCntBits'(HashBits - 1);

  typedef enum logic {
    ERR_NONE  = 1'b0,
    ERR_EMPTY = 1'b1
  } hsr_err_t;

  // One finished key handed from the hashing front to the modulo back end.
  typedef struct packed {
    logic [HashBits-1:0] key_hash;
    hsr_err_t            err;
  } hsr_job_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_DIV  = 2'd1,
    B_HOLD = 2'd2
  } hsr_back_state_t;

  // XOR in one byte, then multiply by the FNV prime 2^40 + 2^8 + 0xB3 (mod 2^64).
  function automatic logic [HashBits-1:0] fnv_step(input logic [HashBits-1:0] h,
                                                   input logic [7:0] b);
    logic [HashBits-1:0] x;
    x = h ^ {{(HashBits-8){1'b0}}, b};
    return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

endpackage

// File: hw/rtl/hsr_front.sv
// Front end of the hash shard router: accepts key bytes and folds them into the
// running FNV-1a hash; pushes one job per finished or empty key. Uses hsr_pkg.
module hsr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        key_byte,
  input  logic              last_byte,
  input  logic              empty_key,
  input  logic              q_full,
  output logic              q_push,
  output hsr_pkg::hsr_job_t q_job
);
  import hsr_pkg::*;

  logic [HashBits-1:0] hash_r;
  logic [HashBits-1:0] hash_nxt;
  logic [HashBits-1:0] step;
  logic                accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign step      = fnv_step(hash_r, key_byte);

  always_comb begin
    hash_nxt       = hash_r;
    q_push         = 1'b0;
    q_job.key_hash = step;
    q_job.err      = ERR_NONE;
    if (accept) begin
      if (empty_key) begin
        // Any partly hashed key is dropped.
        q_push         = 1'b1;
        q_job.key_hash = FnvBasis;
        q_job.err      = ERR_EMPTY;
        hash_nxt       = FnvBasis;
      end else if (last_byte) begin
        q_push   = 1'b1;
        hash_nxt = FnvBasis;
      end else begin
        hash_nxt = step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= FnvBasis;
    end else begin
      hash_r <= hash_nxt;
    end
  end

endmodule

// File: hw/rtl/hsr_queue.sv
// Short job queue between the hashing front and the modulo back end.
// Holds QDepth entries of hsr_job_t; uses hsr_pkg.
module hsr_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hsr_pkg::hsr_job_t push_job,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output hsr_pkg::hsr_job_t head_job
);
  import hsr_pkg::*;

  hsr_job_t            slots_r [QDepth];
  logic [QPtrBits-1:0] wr_ptr_r;
  logic [QPtrBits-1:0] rd_ptr_r;
  logic [QPtrBits:0]   count_r;
  logic                do_push;
  logic                do_pop;

  assign full      = (count_r == (QPtrBits+1)'(QDepth));
  assign not_empty = (count_r != '0);
  assign head_job  = slots_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// File: hw/rtl/hsr_back.sv
// Back end of the hash shard router: reduces each queued hash modulo the shard
// count with a one-bit-per-cycle restoring remainder unit and drives the output
// register. Uses hsr_pkg.
module hsr_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [hsr_pkg::ShardBits-1:0]   num_shards,
  input  logic                            q_not_empty,
  input  hsr_pkg::hsr_job_t               q_head,
  output logic                            q_pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [hsr_pkg::ShardBits-1:0]   shard_number,
  output logic [hsr_pkg::HashBits-1:0]    key_hash,
  output logic                            error_code
);
  import hsr_pkg::*;

  hsr_back_state_t       state_r, state_nxt;
  logic [HashBits-1:0]   job_hash_r, job_hash_nxt;
  hsr_err_t              job_err_r, job_err_nxt;
  logic [HashBits-1:0]   dividend_r, dividend_nxt;
  logic [ShardBits-1:0]  div_r, div_nxt;
  logic [ShardBits-1:0]  rem_r, rem_nxt;
  logic [DivCntBits-1:0] cnt_r, cnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [ShardBits-1:0]  out_shard_r, out_shard_nxt;
  logic [HashBits-1:0]   out_hash_r, out_hash_nxt;
  hsr_err_t              out_err_r, out_err_nxt;
  logic                  out_free;
  logic [ShardBits:0]    trial;
  logic [ShardBits:0]    div_ext;
  logic [ShardBits-1:0]  rem_step;

  assign out_free = !out_valid_r || out_tready;
  assign trial    = {rem_r, dividend_r[HashBits-1]};
  assign div_ext  = {1'b0, div_r};
  assign rem_step = (trial >= div_ext) ? ShardBits'(trial - div_ext) : trial[ShardBits-1:0];

  always_comb begin
    state_nxt     = state_r;
    job_hash_nxt  = job_hash_r;
    job_err_nxt   = job_err_r;
    dividend_nxt  = dividend_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    q_pop         = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_shard_nxt = out_shard_r;
    out_hash_nxt  = out_hash_r;
    out_err_nxt   = out_err_r;
    case (state_r)
      B_IDLE: begin
        if (q_not_empty) begin
          q_pop        = 1'b1;
          job_hash_nxt = q_head.key_hash;
          job_err_nxt  = q_head.err;
          dividend_nxt = q_head.key_hash;
          // A zero shard count behaves as one shard.
          div_nxt      = (num_shards == '0) ? ShardBits'(1) : num_shards;
          rem_nxt      = '0;
          cnt_nxt      = '0;
          state_nxt    = (q_head.err == ERR_EMPTY) ? B_HOLD : B_DIV;
        end
      end
      B_DIV: begin
        rem_nxt      = rem_step;
        dividend_nxt = dividend_r << 1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == DivLast) begin
          state_nxt = B_HOLD;
        end
      end
      B_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hash_nxt  = job_hash_r;
          out_err_nxt   = job_err_r;
          out_shard_nxt = (job_err_r == ERR_EMPTY) ? '0 :
                          (rem_r & ShardBits'((64'd1 << SHARD_ID_BITS) - 64'd1));
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_hash_r  <= job_hash_nxt;
    job_err_r   <= job_err_nxt;
    dividend_r  <= dividend_nxt;
    div_r       <= div_nxt;
    rem_r       <= rem_nxt;
    cnt_r       <= cnt_nxt;
    out_shard_r <= out_shard_nxt;
    out_hash_r  <= out_hash_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign shard_number = out_shard_r;
  assign key_hash     = out_hash_r;
  assign error_code   = out_err_r;

  // The partial remainder never reaches the divisor while dividing.
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_DIV) |-> (rem_r < div_r))
    else $error("remainder not below divisor");

  // A rejected key always reports shard zero.
  a_err_shard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_err_r == ERR_EMPTY)) |-> (out_shard_r == '0))
    else $error("error result with nonzero shard");

  // A valid key taken from the queue goes into the remainder unit next.
  a_pop_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_IDLE && q_not_empty && q_head.err == ERR_NONE) |=> (state_r == B_DIV))
    else $error("valid key did not start division");

endmodule

// File: hw/rtl/hash_shard_router_unit.sv
// Top level of the hash shard router: shard count register, hashing front,
// job queue and modulo back end. Depends on hsr_pkg, hsr_front, hsr_queue, hsr_back.
//
// Usage:
//   Key bytes arrive on the in_ stream, one word per byte; in_tlast marks the
//   final byte and in_tuser flags an empty key. Bytes are hashed (FNV-1a, 64
//   bits) as they arrive, one word per cycle while the job queue has room.
//   Each finished key yields one out_ word: the shard number (hash modulo the
//   shard count) and the full hash; out_tuser is set when an empty key was
//   rejected, with shard number 0 and the hash of an empty key.
//   The modulo is a restoring remainder unit that retires one hash bit per
//   cycle; the back end takes a key from the queue, divides it through all 64
//   hash bits and then loads the output register (an empty key skips the
//   division). It works on one key at a time; the 4-entry queue lets the
//   front keep hashing meanwhile and stalls in_tready when it fills.
//   When out_tready is low, the result is held in the output register, and
//   the back end finishes its next key and waits behind it.
//   cfg_wr_en writes the shard count (0 acts as 1); write it only while idle.
//   Reset (rst_n low, synchronous) sets the shard count to 1, restarts the
//   hash and empties the queue and output register.
module hash_shard_router_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,     // [7:0] key_byte
  input  logic         in_tlast,     // last_byte
  input  logic         in_tuser,     // empty_key
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [79:0]  out_tdata,    // [15:0] shard_number, [79:16] key_hash
  output logic         out_tuser,    // error_code
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data   // num_shards
);
  import hsr_pkg::*;

  logic [ShardBits-1:0] num_shards_r;
  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_not_empty;
  hsr_job_t             push_job;
  hsr_job_t             head_job;
  logic [ShardBits-1:0] shard_number;
  logic [HashBits-1:0]  key_hash;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_shards_r <= ShardBits'(1);
    end else if (cfg_wr_en) begin
      num_shards_r <= cfg_wr_data;
    end
  end

  hsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .key_byte  (in_tdata),
    .last_byte (in_tlast),
    .empty_key (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  hsr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_job  (push_job),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_job  (head_job)
  );

  hsr_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .num_shards   (num_shards_r),
    .q_not_empty  (q_not_empty),
    .q_head       (head_job),
    .q_pop        (q_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .shard_number (shard_number),
    .key_hash     (key_hash),
    .error_code   (out_tuser)
  );

  assign out_tdata = {key_hash, shard_number};

endmodule

// File: tb/sv/hash_shard_router_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for hash_shard_router_unit: directed and random key streams,
// checked against an in-bench FNV-1a hash and modulo predictor. Depends on hsr_pkg.
module hash_shard_router_unit_test;
  import hsr_pkg::*;

  localparam logic [63:0] FnvPrime     = 64'h0000_0100_0000_01B3;
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned IdleLimit    = 3000;
  localparam int unsigned PhaseWords   = 150;
  localparam int unsigned NumPhases    = 10;

  typedef struct packed {
    logic [15:0] shard_number;
    logic [63:0] key_hash;
    hsr_err_t    error_code;
  } route_result_t;

  typedef enum logic {
    ROW_WORD = 1'b0,
    ROW_CFG  = 1'b1
  } plan_kind_t;

  typedef struct packed {
    plan_kind_t    kind;
    logic [15:0]   cfg_val;
    logic [7:0]    key_byte;
    logic          last_byte;
    logic          empty_key;
    logic          typed;
    route_result_t want;
  } plan_row_t;

  localparam route_result_t EmptyKeyResult = '{16'd0, FnvBasis, ERR_EMPTY};
  localparam route_result_t NoResult       = '{16'd0, 64'd0, ERR_NONE};

  // Rows with typed set carry the result that follows directly from the
  // hash definition; all others are predicted.
  localparam int unsigned PlanRows = 22;
  localparam plan_row_t DirectedPlan [PlanRows] = '{
    '{ROW_WORD, 16'd0,     8'h00, 1'b1, 1'b1, 1'b1, EmptyKeyResult},
    '{ROW_WORD, 16'd0,     8'hFF, 1'b0, 1'b1, 1'b1, EmptyKeyResult},
    '{ROW_WORD, 16'd0,     8'h61, 1'b1, 1'b0, 1'b1,
      '{16'd0, 64'hAF63_DC4C_8601_EC8C, ERR_NONE}},
    '{ROW_WORD, 16'd0,     8'h00, 1'b0, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'hFF, 1'b0, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'h12, 1'b1, 1'b1, 1'b1, EmptyKeyResult},
    '{ROW_WORD, 16'd0,     8'hFF, 1'b1, 1'b0, 1'b0, NoResult},
    '{ROW_CFG,  16'hFFFF,  8'h00, 1'b0, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'h00, 1'b0, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'hFF, 1'b1, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'h80, 1'b1, 1'b0, 1'b0, NoResult},
    '{ROW_CFG,  16'd0,     8'h00, 1'b0, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'h5A, 1'b0, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'hA5, 1'b1, 1'b0, 1'b0, NoResult},
    '{ROW_CFG,  16'd2,     8'h00, 1'b0, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'h01, 1'b1, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'h7F, 1'b1, 1'b0, 1'b0, NoResult},
    '{ROW_CFG,  16'd1000,  8'h00, 1'b0, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'h33, 1'b0, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'hCC, 1'b0, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'h0F, 1'b1, 1'b0, 1'b0, NoResult},
    '{ROW_WORD, 16'd0,     8'hFF, 1'b0, 1'b1, 1'b1, EmptyKeyResult}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;     // [7:0] key_byte
  logic        in_tlast = 1'b0;     // last_byte
  logic        in_tuser = 1'b0;     // empty_key
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;           // [15:0] shard_number, [79:16] key_hash
  logic        out_tuser;           // error_code
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0; // num_shards

  // Predictor state, kept in step with the block.
  logic [63:0]   hash_acc = FnvBasis;
  logic [15:0]   shard_cnt = 16'd1;
  route_result_t expected_routes [$];

  int unsigned fail_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned words_sent = 0;
  bit          calm = 1'b0;

  hash_shard_router_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Folds one accepted word into the running hash and reports the result, if any.
  function automatic void fold_key_word(input logic [7:0] b, input logic lst,
                                        input logic emp, output bit got,
                                        output route_result_t res);
    logic [63:0] h;
    logic [63:0] divisor;
    got = 1'b0;
    res = NoResult;
    if (emp) begin
      hash_acc = FnvBasis;
      res = EmptyKeyResult;
      got = 1'b1;
    end else begin
      h = (hash_acc ^ {56'd0, b}) * FnvPrime;
      if (!lst) begin
        hash_acc = h;
      end else begin
        divisor = (shard_cnt == 16'd0) ? 64'd1 : {48'd0, shard_cnt};
        res.shard_number = 16'(h % divisor);
        res.key_hash = h;
        res.error_code = ERR_NONE;
        hash_acc = FnvBasis;
        got = 1'b1;
      end
    end
  endfunction

  task automatic send_word(input logic [7:0] b, input logic lst, input logic emp,
                           input bit typed = 1'b0, input route_result_t want = '0);
    bit got;
    route_result_t res;
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= lst;
    in_tuser  <= emp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    fold_key_word(b, lst, emp, got, res);
    if (got) begin
      expected_routes.push_back(typed ? want : res);
    end
  endtask

  // Waits for the block to drain, lets the back end settle, then writes the count.
  task automatic settle_and_configure(input logic [15:0] count);
    in_tvalid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= count;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shard_cnt = count;
  endtask

  function automatic logic [15:0] pick_num_shards(input int unsigned ph);
    logic [15:0] v;
    case (ph)
      0: v = 16'd1;
      1: v = 16'hFFFF;
      2: v = 16'd0;
      3: v = 16'd1 << $urandom_range(1, 15);
      default: begin
        case ($urandom_range(0, 3))
          0: v = 16'($urandom_range(2, 16));
          1: v = 16'hFFFE;
          default: v = 16'($urandom_range(1, 65535));
        endcase
      end
    endcase
    return v;
  endfunction

  // Mostly well-formed keys of random bytes; some lone empty-key words and
  // some keys cut short by an empty-key word.
  task automatic send_random_key();
    int unsigned sel;
    int unsigned len;
    bit cut_short;
    sel = $urandom_range(0, 15);
    if (sel == 0) begin
      send_word(8'($urandom), 1'($urandom), 1'b1);
    end else begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      cut_short = (sel == 1);
      for (int unsigned i = 0; i < len; i++) begin
        send_word(8'($urandom), (i == len - 1) && !cut_short, 1'b0);
      end
      if (cut_short) begin
        send_word(8'($urandom), 1'($urandom), 1'b1);
      end
    end
  endtask

  // Result side: random stall bursts until the calm stretch at the end.
  initial begin
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 15) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    route_result_t want;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("hash_shard_router_unit test failed");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        if (expected_routes.size() == 0) begin
          $error("unexpected result word: tdata %h tuser %b", out_tdata, out_tuser);
          fail_cnt++;
        end else begin
          want = expected_routes.pop_front();
          if (out_tdata[15:0] !== want.shard_number) begin
            $error("shard_number: expected %0d, got %0d", want.shard_number,
                   out_tdata[15:0]);
            fail_cnt++;
          end
          if (out_tdata[79:16] !== want.key_hash) begin
            $error("key_hash: expected %h, got %h", want.key_hash, out_tdata[79:16]);
            fail_cnt++;
          end
          if (out_tuser !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, out_tuser);
            fail_cnt++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned phase_start;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DirectedPlan[i]) begin
      if (DirectedPlan[i].kind == ROW_CFG) begin
        settle_and_configure(DirectedPlan[i].cfg_val);
      end else begin
        send_word(DirectedPlan[i].key_byte, DirectedPlan[i].last_byte,
                  DirectedPlan[i].empty_key, DirectedPlan[i].typed, DirectedPlan[i].want);
      end
    end

    // Each phase ends on a key boundary, so the count never changes mid-key.
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      settle_and_configure(pick_num_shards(ph));
      calm = (ph == NumPhases - 1);
      phase_start = words_sent;
      while (words_sent - phase_start < PhaseWords) begin
        send_random_key();
      end
    end

    in_tvalid <= 1'b0;
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("hash_shard_router_unit test passed");
    end else begin
      $display("hash_shard_router_unit test failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/hsr_pkg.sv
hw/rtl/hsr_front.sv
hw/rtl/hsr_queue.sv
hw/rtl/hsr_back.sv
hw/rtl/hash_shard_router_unit.sv
tb/sv/hash_shard_router_unit_test.sv
